>>> rtl/utf8_path_name_validator_defines.svh
// Assertion macros for the UTF-8 path name validator checkers.
// Expects i_clk and i_rst_n in the scope of use; no other dependencies.
`ifndef UTF8_PATH_NAME_VALIDATOR_DEFINES_SVH
`define UTF8_PATH_NAME_VALIDATOR_DEFINES_SVH

// Clocked check, ignored while reset is asserted.
`define U8PV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define U8PV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/utf8pv_pkg.sv
// Shared types, constants and decode functions of the UTF-8 path name validator.
// No dependencies.
package utf8pv_pkg;

    localparam int unsigned LENGTH_LIMIT_DEF = 4096;
    localparam int unsigned CFG_W            = 13;
    localparam int unsigned LEN_W            = 13;
    localparam logic [CFG_W-1:0] MAX_LEN_RST = CFG_W'(255);

    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD2_MIN  = 8'hC2;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD_E0    = 8'hE0;
    localparam logic [7:0] LEAD_ED    = 8'hED;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD_F0    = 8'hF0;
    localparam logic [7:0] LEAD_F4    = 8'hF4;
    localparam logic [7:0] CONT_MIN   = 8'h80;
    localparam logic [7:0] CONT_MAX   = 8'hBF;
    localparam logic [7:0] CONT_A0    = 8'hA0;
    localparam logic [7:0] CONT_9F    = 8'h9F;
    localparam logic [7:0] CONT_90    = 8'h90;
    localparam logic [7:0] CONT_8F    = 8'h8F;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_BSL   = 8'h5C;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    // Allowed range of the next continuation byte.
    typedef enum logic [2:0] {
        CLS_80_BF = 3'd0,
        CLS_A0_BF = 3'd1,
        CLS_80_9F = 3'd2,
        CLS_90_BF = 3'd3,
        CLS_80_8F = 3'd4
    } t_cont_class;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       last_byte;
    } t_byte_req;

    typedef struct packed {
        logic        bad;
        logic [1:0]  expect_cnt;
        t_cont_class cls;
    } t_lead;

    function automatic t_lead lead_decode(input logic [7:0] b);
        t_lead d;
        d.bad        = 1'b0;
        d.expect_cnt = 2'd0;
        d.cls        = CLS_80_BF;
        priority if (b <= ASCII_MAX) begin
            d.expect_cnt = 2'd0;
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            d.expect_cnt = 2'd1;
        end else if (b == LEAD_E0) begin
            d.expect_cnt = 2'd2;
            d.cls        = CLS_A0_BF;
        end else if (b == LEAD_ED) begin
            d.expect_cnt = 2'd2;
            d.cls        = CLS_80_9F;
        end else if (b > LEAD_E0 && b <= LEAD3_MAX) begin
            d.expect_cnt = 2'd2;
        end else if (b == LEAD_F0) begin
            d.expect_cnt = 2'd3;
            d.cls        = CLS_90_BF;
        end else if (b > LEAD_F0 && b < LEAD_F4) begin
            d.expect_cnt = 2'd3;
        end else if (b == LEAD_F4) begin
            d.expect_cnt = 2'd3;
            d.cls        = CLS_80_8F;
        end else begin
            d.bad = 1'b1;
        end
        return d;
    endfunction

    function automatic logic cont_ok(input logic [7:0] b, input t_cont_class cls);
        logic ok;
        unique case (cls)
            CLS_A0_BF: ok = (b >= CONT_A0) && (b <= CONT_MAX);
            CLS_80_9F: ok = (b >= CONT_MIN) && (b <= CONT_9F);
            CLS_90_BF: ok = (b >= CONT_90) && (b <= CONT_MAX);
            CLS_80_8F: ok = (b >= CONT_MIN) && (b <= CONT_8F);
            default:   ok = (b >= CONT_MIN) && (b <= CONT_MAX);
        endcase
        return ok;
    endfunction

endpackage

>>> rtl/utf8pv_if.sv
// Handshake channel interfaces of the UTF-8 path name validator.
// Depends on utf8pv_pkg for field widths.
interface utf8pv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic       last_byte;
    modport source (output valid, output name_byte, output last_byte, input ready);
    modport sink   (input valid, input name_byte, input last_byte, output ready);
endinterface

interface utf8pv_result_if;
    logic                        valid;
    logic                        ready;
    logic                        name_valid;
    logic [utf8pv_pkg::LEN_W-1:0] name_length;
    modport source (output valid, output name_valid, output name_length, input ready);
    modport sink   (input valid, input name_valid, input name_length, output ready);
endinterface

interface utf8pv_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [utf8pv_pkg::CFG_W-1:0] max_name_length;
    modport source (output valid, output max_name_length, input ready);
    modport sink   (input valid, input max_name_length, output ready);
endinterface

>>> rtl/utf8pv_in_stage.sv
// Input register stage: captures one name byte request per cycle unless the held request is stalled by the check stage.
// Depends on utf8pv_pkg and utf8pv_if.
module utf8pv_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    utf8pv_byte_if.sink           i_byte,
    output utf8pv_pkg::t_byte_req o_req,
    output logic                  o_req_valid,
    input  logic                  i_req_ready
);

    logic                  r_valid;
    utf8pv_pkg::t_byte_req r_req;

    // Take a new request when empty or when the held one drains this cycle.
    assign i_byte.ready = !r_valid || i_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_valid <= i_byte.valid;
        end
        if (i_byte.ready && i_byte.valid) begin
            r_req.name_byte <= i_byte.name_byte;
            r_req.last_byte <= i_byte.last_byte;
        end
    end

    assign o_req       = r_req;
    assign o_req_valid = r_valid;

endmodule

>>> rtl/utf8pv_check.sv
// Per-name check state and result register of the UTF-8 path name validator.
// Depends on utf8pv_pkg and utf8pv_if.
module utf8pv_check #(
    parameter int unsigned LENGTH_LIMIT = utf8pv_pkg::LENGTH_LIMIT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  utf8pv_pkg::t_byte_req        i_req,
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  logic [utf8pv_pkg::CFG_W-1:0] i_max_len,
    utf8pv_result_if.source              o_result
);

    localparam int unsigned CNT_W = $clog2(LENGTH_LIMIT + 1);
    localparam int unsigned CMP_W = (CNT_W > utf8pv_pkg::CFG_W) ? CNT_W : utf8pv_pkg::CFG_W;

    logic [1:0]              r_expect, n_expect;
    utf8pv_pkg::t_cont_class r_cls, n_cls;
    logic                    r_err, n_err;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_dots, n_dots;
    logic                    r_out_valid;
    logic                    r_out_ok, n_ok;
    logic [utf8pv_pkg::LEN_W-1:0] r_out_len;

    logic                    consume;
    utf8pv_pkg::t_lead       lead;
    logic [CMP_W-1:0]        cnt_ext;

    // A last byte needs a free result slot; other bytes always drain.
    assign consume     = i_req_valid && (!i_req.last_byte || !r_out_valid || o_result.ready);
    assign o_req_ready = consume;
    assign lead        = utf8pv_pkg::lead_decode(i_req.name_byte);

    always_comb begin
        n_expect = r_expect;
        n_cls    = r_cls;
        n_err    = r_err;
        n_dots   = r_dots;
        if (r_cnt == CNT_W'(LENGTH_LIMIT)) begin
            n_cnt = r_cnt;
            n_err = 1'b1;
        end else begin
            n_cnt = r_cnt + CNT_W'(1);
        end
        if (r_expect != 2'd0) begin
            n_cls = utf8pv_pkg::CLS_80_BF;
            if (utf8pv_pkg::cont_ok(i_req.name_byte, r_cls)) begin
                n_expect = r_expect - 2'd1;
            end else begin
                n_expect = 2'd0;
                n_err    = 1'b1;
            end
        end else if (lead.bad) begin
            n_err = 1'b1;
        end else if (lead.expect_cnt != 2'd0) begin
            n_expect = lead.expect_cnt;
            n_cls    = lead.cls;
        end
        if (i_req.name_byte == utf8pv_pkg::CHAR_NUL ||
            i_req.name_byte == utf8pv_pkg::CHAR_SLASH ||
            i_req.name_byte == utf8pv_pkg::CHAR_BSL) begin
            n_err = 1'b1;
        end
        if (i_req.name_byte != utf8pv_pkg::CHAR_DOT) begin
            n_dots = 1'b0;
        end
        cnt_ext = CMP_W'(n_cnt);
        n_ok    = !n_err && (n_expect == 2'd0) && !(n_dots && (n_cnt <= CNT_W'(2)))
                  && (cnt_ext <= CMP_W'(i_max_len));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect    <= 2'd0;
            r_cls       <= utf8pv_pkg::CLS_80_BF;
            r_err       <= 1'b0;
            r_cnt       <= '0;
            r_dots      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (consume && i_req.last_byte) begin
                r_expect    <= 2'd0;
                r_cls       <= utf8pv_pkg::CLS_80_BF;
                r_err       <= 1'b0;
                r_cnt       <= '0;
                r_dots      <= 1'b1;
                r_out_valid <= 1'b1;
            end else begin
                if (consume) begin
                    r_expect <= n_expect;
                    r_cls    <= n_cls;
                    r_err    <= n_err;
                    r_cnt    <= n_cnt;
                    r_dots   <= n_dots;
                end
                if (o_result.ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
        if (consume && i_req.last_byte) begin
            r_out_ok  <= n_ok;
            r_out_len <= cnt_ext[utf8pv_pkg::LEN_W-1:0];
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.name_valid  = r_out_ok;
    assign o_result.name_length = r_out_len;

endmodule

>>> rtl/utf8_path_name_validator.sv
// A name's last byte passes through the input register and then sets its result in the
// check stage's result register, which holds the result until it is taken.
// Throughput: one name byte per cycle, set by the single check stage; a last byte that
// meets an untaken result holds in the input register and stalls the input until it is taken.
// Reset (i_rst_n low, synchronous): clears name state, empties both registers and
// loads the length limit register with 255.
module utf8_path_name_validator #(
    parameter int unsigned LENGTH_LIMIT = utf8pv_pkg::LENGTH_LIMIT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    utf8pv_byte_if.sink     i_byte,
    utf8pv_cfg_if.sink      i_cfg,
    utf8pv_result_if.source o_result
);

    // Configuration: a single writable length limit, always ready.
    logic [utf8pv_pkg::CFG_W-1:0] r_max_len;

    // Request from the input register to the check stage.
    utf8pv_pkg::t_byte_req req;
    logic                  req_valid;
    logic                  req_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= utf8pv_pkg::MAX_LEN_RST;
        end else if (i_cfg.valid) begin
            r_max_len <= i_cfg.max_name_length;
        end
    end

    // Register incoming bytes so the check logic sees a registered input.
    utf8pv_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .o_req       (req),
        .o_req_valid (req_valid),
        .i_req_ready (req_ready)
    );

    // Advance the UTF-8 sequence state, the sticky error, the saturating count
    // and the dot tracker; drop a result into the output register on the last byte.
    utf8pv_check #(
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_max_len   (r_max_len),
        .o_result    (o_result)
    );

endmodule

>>> rtl/utf8pv_checker.sv
// Port-level assertions for the UTF-8 path name validator, bound to the top level.
// Depends on utf8_path_name_validator_defines.svh and utf8pv_pkg.
`include "utf8_path_name_validator_defines.svh"

module utf8pv_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_byte_valid,
    input logic                         i_byte_ready,
    input logic                         i_res_valid,
    input logic                         i_res_ready,
    input logic                         i_res_name_valid,
    input logic [utf8pv_pkg::LEN_W-1:0] i_res_name_length
);

    logic byte_take;
    assign byte_take = i_byte_valid && i_byte_ready;

    `U8PV_ASSERT_ALWAYS(a_rst_empties_result, !i_rst_n |=> !i_res_valid, "result valid after reset")
    `U8PV_ASSERT(a_result_held, i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_name_valid) && $stable(i_res_name_length), "stalled result changed")
    `U8PV_ASSERT(a_ready_when_empty, !i_res_valid |-> i_byte_ready, "input stalled with empty result")
    `U8PV_ASSERT(a_result_has_source, $rose(i_res_valid) |-> $past(byte_take, 2), "result without request")

endmodule

bind utf8_path_name_validator utf8pv_checker u_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_byte_valid      (i_byte.valid),
    .i_byte_ready      (i_byte.ready),
    .i_res_valid       (o_result.valid),
    .i_res_ready       (o_result.ready),
    .i_res_name_valid  (o_result.name_valid),
    .i_res_name_length (o_result.name_length)
);
